/* hdl/line_raster_walker_assert.svh */
// Assertion macros shared by the line raster walker RTL.
// Needs nothing else; each macro expands to one labeled concurrent assertion.
`ifndef LINE_RASTER_WALKER_ASSERT_SVH
`define LINE_RASTER_WALKER_ASSERT_SVH

// Consequent holds in the same cycle as the antecedent.
`define LRW_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("line_raster_walker: assertion failed");

// Consequent holds in the cycle after the antecedent.
`define LRW_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("line_raster_walker: assertion failed");

`endif

/* hdl/lrw_pkg.sv */
// Shared constants and types for the line raster walker.
// No dependencies; imported by lrw_step and line_raster_walker.
package lrw_pkg;

    localparam int ADDR_W  = 32;
    localparam int COLOR_W = 16;
    localparam int STRIDE_W = 16;

    localparam logic [ADDR_W-1:0]   FRAME_BASE_RESET = 32'h0600_0000;
    localparam logic [STRIDE_W-1:0] ROW_STRIDE_RESET = 16'd480;

    // Register index, taken from paddr[2]
    localparam logic REG_FRAME_BASE = 1'b0;
    localparam logic REG_ROW_STRIDE = 1'b1;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_STEP = 1'b1;

    typedef struct packed {
        logic move_y;   // y moves before the plot
        logic done;     // walker has passed the end point
    } step_ctrl_t;

endpackage

/* hdl/lrw_step.sv */
// One walker step: cross-product test, next walker position and plotted pixel.
// Combinational; depends on lrw_pkg for step_ctrl_t.
module lrw_step import lrw_pkg::*; #(
    parameter int COORD_BITS = 10
) (
    input  logic [COORD_BITS-1:0] anchor_x,
    input  logic [COORD_BITS-1:0] anchor_y,
    input  logic [COORD_BITS-1:0] target_x,
    input  logic [COORD_BITS-1:0] target_y,
    input  logic                  rising,
    input  logic [COORD_BITS:0]   walk_x,
    input  logic [COORD_BITS:0]   walk_y,
    output logic [COORD_BITS:0]   walk_x_next,
    output logic [COORD_BITS:0]   walk_y_next,
    output logic [COORD_BITS-1:0] pixel_x,
    output logic [COORD_BITS-1:0] pixel_y,
    output step_ctrl_t            ctrl
);

    // Factors span walk +-1 minus anchor, so two guard bits and a sign bit
    localparam int W = COORD_BITS + 3;

    logic signed [W-1:0]   dx;
    logic signed [W-1:0]   dy;
    logic signed [W-1:0]   x_off;
    logic signed [W-1:0]   y_probe;
    logic signed [W-1:0]   y_off;
    logic signed [2*W-1:0] lhs;
    logic signed [2*W-1:0] rhs;
    logic [COORD_BITS:0]   y_stepped;
    logic                  x_past;
    logic                  y_past;

    always_comb begin
        dx      = signed'(W'(target_x)) - signed'(W'(anchor_x));
        dy      = signed'(W'(target_y)) - signed'(W'(anchor_y));
        x_off   = signed'(W'(walk_x)) - signed'(W'(anchor_x));
        y_probe = rising ? signed'(W'(walk_y)) + W'(1) : signed'(W'(walk_y)) - W'(1);
        y_off   = y_probe - signed'(W'(anchor_y));
        lhs     = dx * y_off;
        rhs     = dy * x_off;

        ctrl.move_y = rising ? (lhs <= rhs) : (lhs > rhs);
        y_stepped   = rising ? walk_y + 1'b1 : walk_y - 1'b1;

        if (ctrl.move_y) begin
            walk_x_next = walk_x;
            walk_y_next = y_stepped;
            pixel_y     = y_stepped[COORD_BITS-1:0];
        end else begin
            walk_x_next = walk_x + 1'b1;
            walk_y_next = walk_y;
            pixel_y     = walk_y[COORD_BITS-1:0];
        end
        pixel_x = walk_x[COORD_BITS-1:0];

        x_past    = walk_x_next > {1'b0, target_x};
        y_past    = rising ? (walk_y_next > {1'b0, target_y})
                           : (walk_y_next < {1'b0, target_y});
        ctrl.done = x_past || y_past;
    end

endmodule

/* hdl/line_raster_walker.sv */
// Line raster walker top level: APB registers, walker state and output pipeline.
// Depends on lrw_pkg, lrw_step and line_raster_walker_assert.svh.
//
// Usage: a transfer on the s_ channel with s_mode = load latches both endpoints and the
// color and starts a walk at the start point; it produces no result. Each transfer with
// s_mode = step while a line is active produces one pixel on the m_ channel (coordinates,
// color, frame-buffer address base + 2x + stride*y); the pixel with m_last set ends the
// line, and steps after it produce nothing until the next load.
// Path: a step's pixel is registered into the inner stage along with the walker update,
// then into the m_ port register after the address multiply-add, and transfers out once
// m_ready is high.
// Throughput: one item per cycle while m_ready stays high; the walker updates on each
// step's transfer, so steps go back to back.
// Stall: with m_ready low, one pixel waits on the m_ port and one more in the inner
// stage; after that s_ready drops until the output drains.
// Reset (aresetn low, synchronous): walker idle, output empty, frame_base = 0x06000000,
// row_stride = 480. Write registers over APB only while the walker has nothing in flight.
`include "line_raster_walker_assert.svh"

module line_raster_walker import lrw_pkg::*; #(
    parameter int COORD_BITS = 10
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    // input items
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_mode,
    input  logic [COORD_BITS-1:0] s_x_start,
    input  logic [COORD_BITS-1:0] s_y_start,
    input  logic [COORD_BITS-1:0] s_x_end,
    input  logic [COORD_BITS-1:0] s_y_end,
    input  logic [COLOR_W-1:0]    s_color,
    // pixels
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [COORD_BITS-1:0] m_pixel_x,
    output logic [COORD_BITS-1:0] m_pixel_y,
    output logic [COLOR_W-1:0]    m_pixel_color,
    output logic [ADDR_W-1:0]     m_pixel_address,
    output logic                  m_last
);

    logic [ADDR_W-1:0]     frame_base_reg;
    logic [STRIDE_W-1:0]   row_stride_reg;

    logic [COORD_BITS-1:0] anchor_x_reg;
    logic [COORD_BITS-1:0] anchor_y_reg;
    logic [COORD_BITS-1:0] target_x_reg;
    logic [COORD_BITS-1:0] target_y_reg;
    logic [COLOR_W-1:0]    line_color_reg;
    logic [COORD_BITS:0]   walk_x_reg;
    logic [COORD_BITS:0]   walk_y_reg;
    logic                  rising_reg;
    logic                  busy_reg;

    logic                  s1_valid_reg;
    logic [COORD_BITS-1:0] s1_x_reg;
    logic [COORD_BITS-1:0] s1_y_reg;
    logic [COLOR_W-1:0]    s1_color_reg;
    logic                  s1_last_reg;

    logic                  m_valid_reg;
    logic [COORD_BITS-1:0] m_x_reg;
    logic [COORD_BITS-1:0] m_y_reg;
    logic [COLOR_W-1:0]    m_color_reg;
    logic [ADDR_W-1:0]     m_address_reg;
    logic                  m_last_reg;

    logic [COORD_BITS:0]   walk_x_next;
    logic [COORD_BITS:0]   walk_y_next;
    logic [COORD_BITS-1:0] step_x;
    logic [COORD_BITS-1:0] step_y;
    step_ctrl_t            step_ctrl;

    logic                  cfg_write;
    logic                  in_xfer;
    logic                  s1_advance;
    logic                  m_load;
    logic                  plot;
    logic [ADDR_W-1:0]     address_next;

    // ---------------------------------------------------------------- config
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = (paddr[2] == REG_ROW_STRIDE) ? 32'(row_stride_reg) : frame_base_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_base_reg <= FRAME_BASE_RESET;
            row_stride_reg <= ROW_STRIDE_RESET;
        end else if (cfg_write) begin
            if (paddr[2] == REG_FRAME_BASE) begin
                frame_base_reg <= pwdata;
            end else begin
                row_stride_reg <= pwdata[STRIDE_W-1:0];
            end
        end
    end

    // ---------------------------------------------------------------- walker
    lrw_step #(
        .COORD_BITS (COORD_BITS)
    ) u_step (
        .anchor_x    (anchor_x_reg),
        .anchor_y    (anchor_y_reg),
        .target_x    (target_x_reg),
        .target_y    (target_y_reg),
        .rising      (rising_reg),
        .walk_x      (walk_x_reg),
        .walk_y      (walk_y_reg),
        .walk_x_next (walk_x_next),
        .walk_y_next (walk_y_next),
        .pixel_x     (step_x),
        .pixel_y     (step_y),
        .ctrl        (step_ctrl)
    );

    assign m_load     = !m_valid_reg || m_ready;
    assign s1_advance = !s1_valid_reg || m_load;
    assign s_ready    = s1_advance;
    assign in_xfer    = s_valid && s_ready;
    assign plot       = in_xfer && (s_mode == MODE_STEP) && busy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            anchor_x_reg   <= '0;
            anchor_y_reg   <= '0;
            target_x_reg   <= '0;
            target_y_reg   <= '0;
            line_color_reg <= '0;
            walk_x_reg     <= '0;
            walk_y_reg     <= '0;
            rising_reg     <= 1'b1;
            busy_reg       <= 1'b0;
        end else if (in_xfer && (s_mode == MODE_LOAD)) begin
            anchor_x_reg   <= s_x_start;
            anchor_y_reg   <= s_y_start;
            target_x_reg   <= s_x_end;
            target_y_reg   <= s_y_end;
            line_color_reg <= s_color;
            walk_x_reg     <= {1'b0, s_x_start};
            walk_y_reg     <= {1'b0, s_y_start};
            rising_reg     <= !(s_y_start > s_y_end);
            busy_reg       <= 1'b1;
        end else if (plot) begin
            walk_x_reg <= walk_x_next;
            walk_y_reg <= walk_y_next;
            if (step_ctrl.done) begin
                busy_reg <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------- pipeline
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s1_advance) begin
            s1_valid_reg <= plot;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_advance && plot) begin
            s1_x_reg     <= step_x;
            s1_y_reg     <= step_y;
            s1_color_reg <= line_color_reg;
            s1_last_reg  <= step_ctrl.done;
        end
    end

    assign address_next = frame_base_reg
                        + ADDR_W'({s1_x_reg, 1'b0})
                        + ADDR_W'(row_stride_reg) * ADDR_W'(s1_y_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (m_load) begin
            m_valid_reg <= s1_valid_reg;
        end
    end

    // hold the output payload while the receiver stalls
    always_ff @(posedge aclk) begin
        if (m_load && s1_valid_reg) begin
            m_x_reg       <= s1_x_reg;
            m_y_reg       <= s1_y_reg;
            m_color_reg   <= s1_color_reg;
            m_address_reg <= address_next;
            m_last_reg    <= s1_last_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_pixel_x       = m_x_reg;
    assign m_pixel_y       = m_y_reg;
    assign m_pixel_color   = m_color_reg;
    assign m_pixel_address = m_address_reg;
    assign m_last          = m_last_reg;

    // ---------------------------------------------------------------- checks
    `LRW_ASSERT_NEXT(a_load_starts_walk, aclk, aresetn, in_xfer && (s_mode == MODE_LOAD), busy_reg)
    `LRW_ASSERT_NEXT(a_idle_step_drops, aclk, aresetn, in_xfer && !busy_reg, !s1_valid_reg)
    `LRW_ASSERT_NEXT(a_done_ends_walk, aclk, aresetn,
        plot && step_ctrl.done && !(s_mode == MODE_LOAD), !busy_reg)
    `LRW_ASSERT_SAME(a_full_blocks_input, aclk, aresetn,
        s1_valid_reg && m_valid_reg && !m_ready, !s_ready)

endmodule

/* bench/tb_top.sv */
// Self-checking bench for line_raster_walker: drives load and step transfers with random
// bursts and gaps, predicts every pixel and its frame-buffer address, and checks m_ results.
// Depends on lrw_pkg and the line_raster_walker RTL; configures the block over its APB port.
module tb_top;
    import lrw_pkg::*;

    localparam int CW          = 10;
    localparam int STALL_LIMIT = 2000;
    localparam int PHASE_ITEMS = 160;
    localparam int REPORT_MAX  = 100;
    localparam int LONG_HOLD   = 400;

    typedef struct packed {
        logic                mode;
        logic [CW-1:0]       xs;
        logic [CW-1:0]       ys;
        logic [CW-1:0]       xe;
        logic [CW-1:0]       ye;
        logic [COLOR_W-1:0]  color;
    } walk_cmd_t;

    typedef struct packed {
        logic [CW-1:0]       x;
        logic [CW-1:0]       y;
        logic [COLOR_W-1:0]  color;
        logic [ADDR_W-1:0]   addr;
        logic                last;
    } pixel_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                psel    = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite  = 1'b0;
    logic [2:0]          paddr   = '0;
    logic [31:0]         pwdata  = '0;
    logic [31:0]         prdata;
    logic                pready;

    logic                s_valid   = 1'b0;
    logic                s_ready;
    logic                s_mode    = MODE_STEP;
    logic [CW-1:0]       s_x_start = '0;
    logic [CW-1:0]       s_y_start = '0;
    logic [CW-1:0]       s_x_end   = '0;
    logic [CW-1:0]       s_y_end   = '0;
    logic [COLOR_W-1:0]  s_color   = '0;

    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [CW-1:0]       m_pixel_x;
    logic [CW-1:0]       m_pixel_y;
    logic [COLOR_W-1:0]  m_pixel_color;
    logic [ADDR_W-1:0]   m_pixel_address;
    logic                m_last;

    line_raster_walker #(.COORD_BITS(CW)) uut (
        .aclk(aclk), .aresetn(aresetn),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_valid(s_valid), .s_ready(s_ready), .s_mode(s_mode),
        .s_x_start(s_x_start), .s_y_start(s_y_start), .s_x_end(s_x_end),
        .s_y_end(s_y_end), .s_color(s_color),
        .m_valid(m_valid), .m_ready(m_ready), .m_pixel_x(m_pixel_x),
        .m_pixel_y(m_pixel_y), .m_pixel_color(m_pixel_color),
        .m_pixel_address(m_pixel_address), .m_last(m_last)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    walk_cmd_t cmd_queue[$];
    pixel_t    expected_pixels[$];

    // Predicted block state
    logic [ADDR_W-1:0]   cfg_frame_base = FRAME_BASE_RESET;
    logic [STRIDE_W-1:0] cfg_row_stride = ROW_STRIDE_RESET;
    logic [CW-1:0]       anc_x = '0, anc_y = '0, tgt_x = '0, tgt_y = '0;
    logic [COLOR_W-1:0]  line_color = '0;
    logic [CW:0]         walk_x = '0, walk_y = '0;
    logic                rising = 1'b1;
    logic                walking = 1'b0;

    int  mismatch_count = 0;
    int  pixels_seen = 0;
    int  stall_cycles = 0;
    logic s_took = 1'b0;

    // Latch a line on load; on a step while walking, move the walker and queue its pixel.
    function automatic void advance_walker(input walk_cmd_t c);
        int          dx, dy, lhs, rhs;
        pixel_t      p;
        logic [31:0] xw, yw, sw;
        if (c.mode == MODE_LOAD) begin
            anc_x = c.xs;
            anc_y = c.ys;
            tgt_x = c.xe;
            tgt_y = c.ye;
            line_color = c.color;
            rising = !(c.ys > c.ye);
            walk_x = {1'b0, c.xs};
            walk_y = {1'b0, c.ys};
            walking = 1'b1;
            return;
        end
        if (!walking)
            return;
        dx  = int'(tgt_x) - int'(anc_x);
        dy  = int'(tgt_y) - int'(anc_y);
        rhs = dy * (int'(walk_x) - int'(anc_x));
        if (rising) begin
            lhs = dx * (int'(walk_y) + 1 - int'(anc_y));
            if (lhs <= rhs) begin
                walk_y = walk_y + 1'b1;
                p.x = walk_x[CW-1:0];
                p.y = walk_y[CW-1:0];
            end else begin
                p.x = walk_x[CW-1:0];
                p.y = walk_y[CW-1:0];
                walk_x = walk_x + 1'b1;
            end
            p.last = (walk_x > tgt_x) || (walk_y > tgt_y);
        end else begin
            lhs = dx * (int'(walk_y) - 1 - int'(anc_y));
            if (lhs > rhs) begin
                walk_y = walk_y - 1'b1;
                p.x = walk_x[CW-1:0];
                p.y = walk_y[CW-1:0];
            end else begin
                p.x = walk_x[CW-1:0];
                p.y = walk_y[CW-1:0];
                walk_x = walk_x + 1'b1;
            end
            p.last = (walk_x > tgt_x) || (walk_y < tgt_y);
        end
        xw = '0;
        yw = '0;
        sw = '0;
        xw[CW-1:0] = p.x;
        yw[CW-1:0] = p.y;
        sw[STRIDE_W-1:0] = cfg_row_stride;
        p.color = line_color;
        p.addr = cfg_frame_base + xw * 32'd2 + sw * yw;
        if (p.last)
            walking = 1'b0;
        expected_pixels.push_back(p);
    endfunction

    // Check pixels, predict on accepted items, track stalls
    always @(posedge aclk) begin
        pixel_t    want;
        walk_cmd_t got_cmd;
        if (!aresetn) begin
            s_took <= 1'b0;
        end else begin
            s_took <= s_valid && s_ready;
            if (m_valid && m_ready) begin
                pixels_seen++;
                if (expected_pixels.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX)
                        $display("%0t: unexpected pixel x=%0d y=%0d color=%h addr=%h last=%b",
                                 $time, m_pixel_x, m_pixel_y, m_pixel_color,
                                 m_pixel_address, m_last);
                end else begin
                    want = expected_pixels.pop_front();
                    if (m_pixel_x !== want.x || m_pixel_y !== want.y ||
                        m_pixel_color !== want.color || m_pixel_address !== want.addr ||
                        m_last !== want.last) begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_MAX)
                            $display({"%0t: pixel expected x=%0d y=%0d color=%h addr=%h ",
                                      "last=%b, got x=%0d y=%0d color=%h addr=%h last=%b"},
                                     $time, want.x, want.y, want.color, want.addr, want.last,
                                     m_pixel_x, m_pixel_y, m_pixel_color, m_pixel_address,
                                     m_last);
                    end
                end
            end
            if (s_valid && s_ready) begin
                got_cmd.mode  = s_mode;
                got_cmd.xs    = s_x_start;
                got_cmd.ys    = s_y_start;
                got_cmd.xe    = s_x_end;
                got_cmd.ye    = s_y_end;
                got_cmd.color = s_color;
                advance_walker(got_cmd);
            end
            if ((m_valid && m_ready) || (s_valid && s_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
    end

    // Sender: bursts of random length with random gaps
    int gap_left = 0;
    int burst_left = 0;
    always @(negedge aclk) begin
        walk_cmd_t c;
        if (aresetn && (!s_valid || s_took)) begin
            if (gap_left > 0) begin
                gap_left--;
                s_valid <= 1'b0;
            end else if (cmd_queue.size() != 0) begin
                c = cmd_queue.pop_front();
                s_mode    <= c.mode;
                s_x_start <= c.xs;
                s_y_start <= c.ys;
                s_x_end   <= c.xe;
                s_y_end   <= c.ye;
                s_color   <= c.color;
                s_valid   <= 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
                                                             : $urandom_range(1, 20);
                    gap_left = $urandom_range(1, 12);
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver: stall pattern of its own plus one long hold-off while items keep coming
    int  hold_left = 0;
    int  pattern = 0;
    int  pattern_left = 0;
    logic hold_done = 1'b0;
    always @(negedge aclk) begin
        if (!hold_done && pixels_seen >= 60 && cmd_queue.size() > 30) begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            if (pattern_left == 0) begin
                pattern = $urandom_range(0, 2);
                pattern_left = $urandom_range(10, 60);
            end else begin
                pattern_left--;
            end
            case (pattern)
                0: begin
                    m_ready <= 1'b1;
                end
                1: begin
                    m_ready <= ($urandom_range(0, 1) == 1);
                end
                default: begin
                    m_ready <= ($urandom_range(0, 3) == 0);
                end
            endcase
        end
    end

    task automatic write_reg(input logic idx, input logic [31:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (idx == REG_FRAME_BASE)
            cfg_frame_base = value;
        else
            cfg_row_stride = value[STRIDE_W-1:0];
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic void push_load(input int xs, input int ys, input int xe, input int ye,
                                      input int color);
        walk_cmd_t c;
        c.mode  = MODE_LOAD;
        c.xs    = xs[CW-1:0];
        c.ys    = ys[CW-1:0];
        c.xe    = xe[CW-1:0];
        c.ye    = ye[CW-1:0];
        c.color = color[COLOR_W-1:0];
        cmd_queue.push_back(c);
    endfunction

    // Steps carry junk in the coordinate fields; the block must ignore it
    function automatic void push_steps(input int n);
        walk_cmd_t c;
        repeat (n) begin
            c.mode  = MODE_STEP;
            c.xs    = CW'($urandom_range(0, 1023));
            c.ys    = CW'($urandom_range(0, 1023));
            c.xe    = CW'($urandom_range(0, 1023));
            c.ye    = CW'($urandom_range(0, 1023));
            c.color = COLOR_W'($urandom_range(0, 65535));
            cmd_queue.push_back(c);
        end
    endfunction

    function automatic int clip_coord(input int v);
        if (v < 0)
            return 0;
        if (v > 1023)
            return 1023;
        return v;
    endfunction

    // Mostly complete lines with random content; some cut short, far apart, or stray steps
    function automatic void queue_random_lines(input int quota);
        int made, kind, xs, ys, xe, ye, n;
        made = 0;
        while (made < quota) begin
            kind = $urandom_range(0, 99);
            xs = $urandom_range(0, 1023);
            ys = $urandom_range(0, 1023);
            if (kind < 8) begin
                push_steps($urandom_range(1, 4));
            end else begin
                if (kind < 14) begin
                    xe = $urandom_range(0, 1023);
                    ye = $urandom_range(0, 1023);
                end else begin
                    xe = ($urandom_range(0, 7) == 0) ? xs - $urandom_range(1, 20)
                                                     : xs + $urandom_range(0, 20);
                    ye = ($urandom_range(0, 1) == 0) ? ys - $urandom_range(0, 20)
                                                     : ys + $urandom_range(0, 20);
                    xe = clip_coord(xe);
                    ye = clip_coord(ye);
                end
                n = ((xe >= xs) ? xe - xs : 0) + ((ye >= ys) ? ye - ys : ys - ye)
                    + $urandom_range(0, 2);
                if (kind < 14 || kind >= 88)
                    n = $urandom_range(0, (n < 40) ? n : 40);
                push_load(xs, ys, xe, ye, $urandom_range(0, 65535));
                push_steps(n);
                made += n + 1;
            end
        end
    endfunction

    task automatic wait_drained();
        while (cmd_queue.size() != 0 || s_valid || expected_pixels.size() != 0)
            @(posedge aclk);
        // a trailing load or ignored step may still be in the pipe
        repeat (6) @(posedge aclk);
    endtask

    initial begin
        while (stall_cycles < STALL_LIMIT)
            @(posedge aclk);
        $display("Mismatches found");
        $finish;
    end

    initial begin
        int ph;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Steps before any load produce nothing
        push_steps(2);
        push_load(0, 0, 2, 2, 16'h0000);
        push_steps(5);
        // Vertical rising line to the top row wraps its last pixel to y 0
        push_load(7, 1020, 7, 1023, 16'hFFFF);
        push_steps(5);
        // Vertical falling line plots one point
        push_load(1023, 5, 1023, 2, 16'hA5A5);
        push_steps(2);
        // Load in the middle of a walk restarts it
        push_load(3, 3, 1023, 0, 16'h5A5A);
        push_steps(2);
        // Reversed x
        push_load(1023, 0, 0, 1023, 16'h1234);
        push_steps(2);
        wait_drained();

        for (ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin
                    write_reg(REG_FRAME_BASE, 32'h0000_0000);
                    write_reg(REG_ROW_STRIDE, 32'h0000_0000);
                end
                1: begin
                    write_reg(REG_FRAME_BASE, 32'hFFFF_FFFF);
                    write_reg(REG_ROW_STRIDE, 32'h0000_FFFF);
                end
                2: begin
                    write_reg(REG_FRAME_BASE, $urandom);
                    write_reg(REG_ROW_STRIDE, 32'd1);
                end
                default: begin
                    write_reg(REG_FRAME_BASE, $urandom);
                    write_reg(REG_ROW_STRIDE, $urandom_range(0, 65535));
                end
            endcase
            queue_random_lines(PHASE_ITEMS);
            wait_drained();
        end

        repeat (10) @(posedge aclk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
